>>> rtl/dhc_pkg.sv
package dhc_pkg;

   localparam int PIX_W   = 8;
   localparam int QUOT_W  = 8;
   localparam int NUM_W   = 16;
   localparam int REM_W   = 6;

   localparam logic [NUM_W-1:0] HUE_SPAN    = 16'd240;
   localparam logic [PIX_W-1:0] HUE_TOP     = 8'd240;
   localparam logic [PIX_W-1:0] SECTOR_SPAN = 8'd60;
   localparam logic [PIX_W-1:0] CH_FULL     = 8'hFF;
   localparam logic [PIX_W-1:0] CH_ZERO     = 8'h00;

   typedef enum logic [2:0] {
      SEC_RED_YELLOW   = 3'd0,
      SEC_YELLOW_GREEN = 3'd1,
      SEC_GREEN_CYAN   = 3'd2,
      SEC_CYAN_BLUE    = 3'd3,
      SEC_BLUE_MAGENTA = 3'd4,
      SEC_MAGENTA_RED  = 3'd5
   } sector_type;

   typedef struct packed {
      logic              valid;
      logic              blank;
      logic [PIX_W-1:0]  m;
      logic [NUM_W-1:0]  rem;
      logic [QUOT_W-1:0] quot;
   } div_type;

   typedef struct packed {
      logic             valid;
      logic             blank;
      sector_type       sector;
      logic [REM_W-1:0] frac;
   } hue_type;

   // one restoring step: quotient bit sh
   function automatic div_type div_step(div_type s, logic [2:0] sh);
      div_type          r;
      logic [NUM_W-1:0] dv;
      r  = s;
      dv = {{(NUM_W-PIX_W){1'b0}}, s.m} << sh;
      if (s.rem >= dv) begin
         r.rem      = s.rem - dv;
         r.quot[sh] = 1'b1;
      end
      return r;
   endfunction

endpackage

>>> rtl/dhc_front.sv
module dhc_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  logic [dhc_pkg::PIX_W-1:0]  disparity,
   input  logic [dhc_pkg::PIX_W-1:0]  max_disp,
   output dhc_pkg::div_type           div_in
);
   import dhc_pkg::*;

   div_type          front_ff;
   div_type          front_in;
   logic [PIX_W-1:0] dsat;
   logic [PIX_W-1:0] diff;

   always_comb begin
      dsat           = (disparity > max_disp) ? max_disp : disparity;
      diff           = max_disp - dsat;
      front_in.valid = in_valid;
      front_in.blank = (max_disp == CH_ZERO) || (disparity == CH_ZERO);
      front_in.m     = max_disp;
      front_in.rem   = {{(NUM_W-PIX_W){1'b0}}, diff} * HUE_SPAN;
      front_in.quot  = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff.valid <= 1'b0;
      end else begin
         front_ff <= front_in;
      end
   end

   assign div_in = front_ff;

endmodule

>>> rtl/dhc_div.sv
module dhc_div #(
   parameter int STEPS_PER_STAGE = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  dhc_pkg::div_type div_in,
   output dhc_pkg::div_type div_out
);
   import dhc_pkg::*;

   localparam int STAGE_CNT = QUOT_W / STEPS_PER_STAGE;

   div_type stage_src [STAGE_CNT];
   div_type stage_in  [STAGE_CNT];
   div_type stage_ff  [STAGE_CNT];

   assign stage_src[0] = div_in;

   genvar k;
   for (k = 0; k < STAGE_CNT; k++) begin : g_stage
      if (k > 0) begin : g_link
         assign stage_src[k] = stage_ff[k-1];
      end

      always_comb begin
         div_type v;
         v = stage_src[k];
         for (int j = 0; j < STEPS_PER_STAGE; j++) begin
            v = div_step(v, 3'(QUOT_W - 1 - k * STEPS_PER_STAGE - j));
         end
         stage_in[k] = v;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            stage_ff[k].valid <= 1'b0;
         end else begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   assign div_out = stage_ff[STAGE_CNT-1];

endmodule

>>> rtl/dhc_color.sv
module dhc_color (
   input  logic                       clock,
   input  logic                       reset,
   input  dhc_pkg::div_type           div_out,
   output logic                       rsp_valid,
   output logic [dhc_pkg::PIX_W-1:0]  rsp_blue,
   output logic [dhc_pkg::PIX_W-1:0]  rsp_green,
   output logic [dhc_pkg::PIX_W-1:0]  rsp_red
);
   import dhc_pkg::*;

   hue_type          hue_ff;
   hue_type          hue_in;
   logic [PIX_W-1:0] base;
   logic [PIX_W-1:0] h;

   logic             valid_ff;
   logic             valid_in;
   logic [PIX_W-1:0] blue_ff, green_ff, red_ff;
   logic [PIX_W-1:0] blue_in, green_in, red_in;
   logic [10:0]      t_full, q_full;
   logic [PIX_W-1:0] t, q;

   // hue to sector and remainder
   always_comb begin
      h = div_out.quot;
      priority if (h >= HUE_TOP) begin
         hue_in.sector = SEC_BLUE_MAGENTA;
         base          = HUE_TOP;
      end else if (h >= 8'd180) begin
         hue_in.sector = SEC_CYAN_BLUE;
         base          = 8'd180;
      end else if (h >= 8'd120) begin
         hue_in.sector = SEC_GREEN_CYAN;
         base          = 8'd120;
      end else if (h >= SECTOR_SPAN) begin
         hue_in.sector = SEC_YELLOW_GREEN;
         base          = SECTOR_SPAN;
      end else begin
         hue_in.sector = SEC_RED_YELLOW;
         base          = CH_ZERO;
      end
      hue_in.valid = div_out.valid;
      hue_in.blank = div_out.blank;
      hue_in.frac  = REM_W'(h - base);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hue_ff.valid <= 1'b0;
      end else begin
         hue_ff <= hue_in;
      end
   end

   // ramps: floor(r*17/4) and floor((60-r)*17/4)
   always_comb begin
      t_full   = {5'b0, hue_ff.frac} * 11'd17;
      q_full   = {5'b0, REM_W'(SECTOR_SPAN) - hue_ff.frac} * 11'd17;
      t        = PIX_W'(t_full >> 2);
      q        = PIX_W'(q_full >> 2);
      valid_in = hue_ff.valid;
      unique case (hue_ff.sector)
         SEC_RED_YELLOW: begin
            blue_in = CH_ZERO; green_in = t;       red_in = CH_FULL;
         end
         SEC_YELLOW_GREEN: begin
            blue_in = CH_ZERO; green_in = CH_FULL; red_in = q;
         end
         SEC_GREEN_CYAN: begin
            blue_in = t;       green_in = CH_FULL; red_in = CH_ZERO;
         end
         SEC_CYAN_BLUE: begin
            blue_in = CH_FULL; green_in = q;       red_in = CH_ZERO;
         end
         SEC_BLUE_MAGENTA: begin
            blue_in = CH_FULL; green_in = CH_ZERO; red_in = t;
         end
         default: begin
            blue_in = q;       green_in = CH_ZERO; red_in = CH_FULL;
         end
      endcase
      if (hue_ff.blank) begin
         blue_in  = CH_ZERO;
         green_in = CH_ZERO;
         red_in   = CH_ZERO;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      blue_ff  <= blue_in;
      green_ff <= green_in;
      red_ff   <= red_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_blue  = blue_ff;
   assign rsp_green = green_ff;
   assign rsp_red   = red_ff;

endmodule

>>> rtl/disparity_hue_colorizer_core.sv
// Disparity to BGR hue colorizer. One pixel may be started in every clock
// cycle; busy is high only during reset and the first cycle after it. Each
// transaction returns exactly one result on rsp_valid with rsp_blue,
// rsp_green and rsp_red, in start order, after the front register, the
// divider stages, the hue register and the output register. The receiver
// cannot stall the block: every result is shown for a single cycle and
// must be taken then. The hue is formed by a restoring divider, which
// retires STEPS_PER_STAGE quotient bits per pipeline stage (1, 2, 4 or 8).
// max_disparity is written through csr_wr_en/csr_wr_data and must only be
// changed while no transaction is in flight; zero forces black output.
module disparity_hue_colorizer_core #(
   parameter int STEPS_PER_STAGE = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic [dhc_pkg::PIX_W-1:0]  req_disparity,
   input  logic                       csr_wr_en,
   input  logic [dhc_pkg::PIX_W-1:0]  csr_wr_data,
   output logic                       rsp_valid,
   output logic [dhc_pkg::PIX_W-1:0]  rsp_blue,
   output logic [dhc_pkg::PIX_W-1:0]  rsp_green,
   output logic [dhc_pkg::PIX_W-1:0]  rsp_red
);
   import dhc_pkg::*;

   logic             busy_ff;
   logic [PIX_W-1:0] max_disp_ff;
   logic             accept;
   div_type          div_in;
   div_type          div_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b1;
         max_disp_ff <= '0;
      end else begin
         busy_ff <= 1'b0;
         if (csr_wr_en) begin
            max_disp_ff <= csr_wr_data;
         end
      end
   end

   assign busy   = busy_ff;
   assign accept = start && !busy_ff;

   dhc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .disparity (req_disparity),
      .max_disp  (max_disp_ff),
      .div_in    (div_in)
   );

   dhc_div #(
      .STEPS_PER_STAGE (STEPS_PER_STAGE)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .div_in  (div_in),
      .div_out (div_out)
   );

   dhc_color u_color (
      .clock     (clock),
      .reset     (reset),
      .div_out   (div_out),
      .rsp_valid (rsp_valid),
      .rsp_blue  (rsp_blue),
      .rsp_green (rsp_green),
      .rsp_red   (rsp_red)
   );

   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      (div_out.valid && !div_out.blank) |-> (div_out.quot <= HUE_TOP))
      else $error("hue quotient out of range");

   a_one_dark: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_blue == CH_ZERO || rsp_green == CH_ZERO || rsp_red == CH_ZERO))
      else $error("colorized pixel has no zero channel");

endmodule
